// ===== rtl/core/mcr_pkg.sv =====
package mcr_pkg;

   localparam int COORD_BITS_DEF  = 12;
   localparam int RADIUS_BITS_DEF = 10;

   // Width of every result coordinate on the result port.
   localparam int OUT_W       = 14;
   localparam int KIND_W      = 2;
   localparam int OUT_DATA_W  = ((3 * OUT_W + 7) / 8) * 8;
   localparam int OUT_PAD_W   = OUT_DATA_W - 3 * OUT_W;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_POINT = 2'd0,
      KIND_SPAN  = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_OUTLINE = 3'b001,
      PH_FILL    = 3'b010,
      PH_DONE    = 3'b100
   } phase_type;

   // A step tick handed from the walk to the result sequencer.
   typedef struct packed {
      logic      valid;
      phase_type phase;
   } step_ctl_type;

endpackage

// ===== rtl/core/mcr_walk.sv =====
module mcr_walk import mcr_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          cmd,
   input  logic [COORD_BITS-1:0]         center_x,
   input  logic [COORD_BITS-1:0]         center_y,
   input  logic [RADIUS_BITS-1:0]        radius,
   input  logic                          fill_mode,
   output step_ctl_type                  snap,
   output logic [COORD_BITS-1:0]         snap_col,
   output logic [COORD_BITS-1:0]         snap_row,
   output logic signed [RADIUS_BITS:0]   snap_ox,
   output logic signed [RADIUS_BITS:0]   snap_oy
);

   localparam int OFF_W = RADIUS_BITS + 1;
   localparam int DEC_W = RADIUS_BITS + 3;
   localparam int EXT_W = DEC_W + 1;
   localparam logic signed [OFF_W-1:0] OFF_ONE = 1;
   localparam logic signed [DEC_W-1:0] DEC_ONE = 1;
   localparam logic signed [EXT_W-1:0] EXT_ONE = 1;

   logic [COORD_BITS-1:0]         center_col_ff, center_col_in;
   logic [COORD_BITS-1:0]         center_row_ff, center_row_in;
   logic [RADIUS_BITS-1:0]        radius_ff, radius_in;
   logic                          fill_ff, fill_in;
   logic signed [OFF_W-1:0]       off_x_ff, off_x_in;
   logic signed [OFF_W-1:0]       off_y_ff, off_y_in;
   logic signed [DEC_W-1:0]       dec_ff, dec_in;
   phase_type                     phase_ff, phase_in;

   logic signed [EXT_W-1:0]       d_e, ox_e, oy_e, r_e, dy_e, t_e, d_n;
   logic signed [OFF_W-1:0]       ox_n, oy_n;
   logic signed [OFF_W-1:0]       held_oy;
   logic signed [DEC_W-1:0]       held_dec;
   logic                          ended;

   // One midpoint decision step from the current walk position.
   always_comb begin
      d_e  = EXT_W'(dec_ff);
      ox_e = EXT_W'(off_x_ff);
      oy_e = EXT_W'(off_y_ff);
      r_e  = EXT_W'($signed({1'b0, radius_ff}));
      dy_e = r_e - oy_e;
      t_e  = oy_e - ox_e - EXT_ONE;
      d_n  = d_e;
      ox_n = off_x_ff;
      oy_n = off_y_ff;
      if (d_e >= ox_e + ox_e) begin
         d_n  = d_e - (ox_e + ox_e + EXT_ONE);
         ox_n = off_x_ff + OFF_ONE;
      end else if (d_e < dy_e + dy_e) begin
         d_n  = d_e + oy_e + oy_e - EXT_ONE;
         oy_n = off_y_ff - OFF_ONE;
      end else begin
         d_n  = d_e + t_e + t_e;
         ox_n = off_x_ff + OFF_ONE;
         oy_n = off_y_ff - OFF_ONE;
      end
      ended = oy_n < ox_n;
   end

   assign held_oy  = $signed({1'b0, radius_ff});
   assign held_dec = DEC_W'($signed({1'b0, radius_ff})) - DEC_ONE;

   always_comb begin
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      radius_in     = radius_ff;
      fill_in       = fill_ff;
      off_x_in      = off_x_ff;
      off_y_in      = off_y_ff;
      dec_in        = dec_ff;
      phase_in      = phase_ff;
      if (accept) begin
         if (cmd == CMD_START) begin
            center_col_in = center_x;
            center_row_in = center_y;
            radius_in     = radius;
            fill_in       = fill_mode;
            off_x_in      = '0;
            off_y_in      = $signed({1'b0, radius});
            dec_in        = DEC_W'($signed({1'b0, radius})) - DEC_ONE;
            phase_in      = PH_OUTLINE;
         end else begin
            unique case (phase_ff)
               PH_OUTLINE: begin
                  off_x_in = ox_n;
                  off_y_in = oy_n;
                  dec_in   = DEC_W'(d_n);
                  if (ended) begin
                     if (fill_ff) begin
                        off_x_in = '0;
                        off_y_in = held_oy;
                        dec_in   = held_dec;
                        phase_in = PH_FILL;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
               end
               PH_FILL: begin
                  off_x_in = ox_n;
                  off_y_in = oy_n;
                  dec_in   = DEC_W'(d_n);
                  if (ended) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      center_col_ff <= center_col_in;
      center_row_ff <= center_row_in;
      radius_ff     <= radius_in;
      fill_ff       <= fill_in;
      off_x_ff      <= off_x_in;
      off_y_ff      <= off_y_in;
      dec_ff        <= dec_in;
      if (reset) begin
         phase_ff <= PH_DONE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // The results of a tick come from the position before its advance.
   always_comb begin
      snap.valid = accept && (cmd == CMD_TICK);
      if (phase_ff == PH_OUTLINE || phase_ff == PH_FILL) begin
         snap.phase = phase_ff;
      end else begin
         snap.phase = PH_DONE;
      end
   end

   assign snap_col = center_col_ff;
   assign snap_row = center_row_ff;
   assign snap_ox  = off_x_ff;
   assign snap_oy  = off_y_ff;

endmodule

// ===== rtl/core/mcr_emit.sv =====
module mcr_emit import mcr_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  step_ctl_type                  snap,
   input  logic [COORD_BITS-1:0]         snap_col,
   input  logic [COORD_BITS-1:0]         snap_row,
   input  logic signed [RADIUS_BITS:0]   snap_ox,
   input  logic signed [RADIUS_BITS:0]   snap_oy,
   output logic                          step_ready,
   input  logic                          out_ready,
   output logic                          out_valid,
   output kind_type                      out_kind,
   output logic signed [OUT_W-1:0]       out_x_left,
   output logic signed [OUT_W-1:0]       out_x_right,
   output logic signed [OUT_W-1:0]       out_row_y,
   output logic                          out_last
);

   localparam int OFF_W = RADIUS_BITS + 1;
   localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] IDX_ONE     = 1;
   localparam logic [IDX_W-1:0] IDX_OUTLINE = 7;
   localparam logic [IDX_W-1:0] IDX_FILL    = 3;

   // Pending slot: one accepted tick waiting for the sequencer.
   logic                    pend_valid_ff, pend_valid_in;
   phase_type               pend_phase_ff, pend_phase_in;
   logic [COORD_BITS-1:0]   pend_col_ff, pend_col_in;
   logic [COORD_BITS-1:0]   pend_row_ff, pend_row_in;
   logic signed [OFF_W-1:0] pend_ox_ff, pend_ox_in;
   logic signed [OFF_W-1:0] pend_oy_ff, pend_oy_in;

   // Tick whose results are being sent.
   logic                    job_valid_ff, job_valid_in;
   phase_type               job_phase_ff, job_phase_in;
   logic [COORD_BITS-1:0]   job_col_ff, job_col_in;
   logic [COORD_BITS-1:0]   job_row_ff, job_row_in;
   logic signed [OFF_W-1:0] job_ox_ff, job_ox_in;
   logic signed [OFF_W-1:0] job_oy_ff, job_oy_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;

   logic                    out_valid_ff, out_valid_in;
   kind_type                out_kind_ff, out_kind_in;
   logic signed [OUT_W-1:0] out_xl_ff, out_xl_in;
   logic signed [OUT_W-1:0] out_xr_ff, out_xr_in;
   logic signed [OUT_W-1:0] out_ry_ff, out_ry_in;
   logic                    out_last_ff, out_last_in;

   logic                    out_free, job_take;
   logic [IDX_W-1:0]        idx_last;
   logic signed [SUM_W-1:0] cx_s, cy_s, ox_s, oy_s;
   logic signed [SUM_W-1:0] xpa, xma, xpb, xmb, ypa, yma, ypb, ymb;

   assign out_free   = !out_valid_ff || out_ready;
   assign step_ready = !pend_valid_ff;

   always_comb begin
      unique case (job_phase_ff)
         PH_OUTLINE: idx_last = IDX_OUTLINE;
         PH_FILL:    idx_last = IDX_FILL;
         default:    idx_last = '0;
      endcase
   end

   assign job_take = !job_valid_ff || (out_free && idx_ff == idx_last);

   always_comb begin
      pend_valid_in = snap.valid || (pend_valid_ff && !job_take);
      pend_phase_in = pend_phase_ff;
      pend_col_in   = pend_col_ff;
      pend_row_in   = pend_row_ff;
      pend_ox_in    = pend_ox_ff;
      pend_oy_in    = pend_oy_ff;
      if (snap.valid) begin
         pend_phase_in = snap.phase;
         pend_col_in   = snap_col;
         pend_row_in   = snap_row;
         pend_ox_in    = snap_ox;
         pend_oy_in    = snap_oy;
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_phase_in = job_phase_ff;
      job_col_in   = job_col_ff;
      job_row_in   = job_row_ff;
      job_ox_in    = job_ox_ff;
      job_oy_in    = job_oy_ff;
      idx_in       = idx_ff;
      if (job_take) begin
         job_valid_in = pend_valid_ff;
         job_phase_in = pend_phase_ff;
         job_col_in   = pend_col_ff;
         job_row_in   = pend_row_ff;
         job_ox_in    = pend_ox_ff;
         job_oy_in    = pend_oy_ff;
         idx_in       = '0;
      end else if (out_free) begin
         idx_in = idx_ff + IDX_ONE;
      end
   end

   assign cx_s = SUM_W'($signed({1'b0, job_col_ff}));
   assign cy_s = SUM_W'($signed({1'b0, job_row_ff}));
   assign ox_s = SUM_W'(job_ox_ff);
   assign oy_s = SUM_W'(job_oy_ff);
   assign xpa  = cx_s + ox_s;
   assign xma  = cx_s - ox_s;
   assign xpb  = cx_s + oy_s;
   assign xmb  = cx_s - oy_s;
   assign ypa  = cy_s + ox_s;
   assign yma  = cy_s - ox_s;
   assign ypb  = cy_s + oy_s;
   assign ymb  = cy_s - oy_s;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_xl_in    = out_xl_ff;
      out_xr_in    = out_xr_ff;
      out_ry_in    = out_ry_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = job_valid_ff;
         out_last_in  = (idx_ff == idx_last);
         unique case (job_phase_ff)
            PH_OUTLINE: begin
               out_kind_in = KIND_POINT;
               unique case (idx_ff)
                  3'd0: begin out_xl_in = OUT_W'(xpa); out_ry_in = OUT_W'(ypb); end
                  3'd1: begin out_xl_in = OUT_W'(xpb); out_ry_in = OUT_W'(ypa); end
                  3'd2: begin out_xl_in = OUT_W'(xma); out_ry_in = OUT_W'(ypb); end
                  3'd3: begin out_xl_in = OUT_W'(xmb); out_ry_in = OUT_W'(ypa); end
                  3'd4: begin out_xl_in = OUT_W'(xpa); out_ry_in = OUT_W'(ymb); end
                  3'd5: begin out_xl_in = OUT_W'(xpb); out_ry_in = OUT_W'(yma); end
                  3'd6: begin out_xl_in = OUT_W'(xma); out_ry_in = OUT_W'(ymb); end
                  default: begin out_xl_in = OUT_W'(xmb); out_ry_in = OUT_W'(yma); end
               endcase
               out_xr_in = out_xl_in;
            end
            PH_FILL: begin
               out_kind_in = KIND_SPAN;
               unique case (idx_ff)
                  3'd0: begin
                     out_xl_in = OUT_W'(xmb);
                     out_xr_in = OUT_W'(xpb);
                     out_ry_in = OUT_W'(ypa);
                  end
                  3'd1: begin
                     out_xl_in = OUT_W'(xma);
                     out_xr_in = OUT_W'(xpa);
                     out_ry_in = OUT_W'(ypb);
                  end
                  3'd2: begin
                     out_xl_in = OUT_W'(xma);
                     out_xr_in = OUT_W'(xpa);
                     out_ry_in = OUT_W'(ymb);
                  end
                  default: begin
                     out_xl_in = OUT_W'(xmb);
                     out_xr_in = OUT_W'(xpb);
                     out_ry_in = OUT_W'(yma);
                  end
               endcase
            end
            default: begin
               out_kind_in = KIND_DONE;
               out_xl_in   = '0;
               out_xr_in   = '0;
               out_ry_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pend_phase_ff <= pend_phase_in;
      pend_col_ff   <= pend_col_in;
      pend_row_ff   <= pend_row_in;
      pend_ox_ff    <= pend_ox_in;
      pend_oy_ff    <= pend_oy_in;
      job_phase_ff  <= job_phase_in;
      job_col_ff    <= job_col_in;
      job_row_ff    <= job_row_in;
      job_ox_ff     <= job_ox_in;
      job_oy_ff     <= job_oy_in;
      idx_ff        <= idx_in;
      out_kind_ff   <= out_kind_in;
      out_xl_ff     <= out_xl_in;
      out_xr_ff     <= out_xr_in;
      out_ry_ff     <= out_ry_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         job_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         job_valid_ff  <= job_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_kind    = out_kind_ff;
   assign out_x_left  = out_xl_ff;
   assign out_x_right = out_xr_ff;
   assign out_row_y   = out_ry_ff;
   assign out_last    = out_last_ff;

endmodule

// ===== rtl/core/midpoint_circle_rasterizer_unit.sv =====
// Pipeline: a step tick's results pass through the pending slot, the job register and
// the output register. A start gives no result; a tick gives eight points (outline),
// four spans (fill) or one done marker, at one result per cycle on the result port
// while rsp_tready is held high.
// Reset: synchronous, active high; the walk enters the done phase and all queues empty.
module midpoint_circle_rasterizer_unit import mcr_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   localparam int IN_W       = 2 * COORD_BITS + RADIUS_BITS + 1,
   localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // center_x, center_y, radius, fill_mode, zero pad
   input  logic [IN_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // x_left, x_right, row_y, zero pad
   output logic [OUT_DATA_W-1:0]  rsp_tdata,
   // kind
   output logic [KIND_W-1:0]      rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int CY_LO = COORD_BITS;
   localparam int R_LO  = 2 * COORD_BITS;
   localparam int F_BIT = 2 * COORD_BITS + RADIUS_BITS;

   step_ctl_type                snap;
   logic [COORD_BITS-1:0]       snap_col, snap_row;
   logic signed [RADIUS_BITS:0] snap_ox, snap_oy;
   logic                        accept;
   kind_type                    out_kind;
   logic signed [OUT_W-1:0]     out_xl, out_xr, out_ry;

   assign accept = req_tvalid && req_tready;

   mcr_walk #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_tuser[0]),
      .center_x  (req_tdata[COORD_BITS-1:0]),
      .center_y  (req_tdata[CY_LO +: COORD_BITS]),
      .radius    (req_tdata[R_LO +: RADIUS_BITS]),
      .fill_mode (req_tdata[F_BIT]),
      .snap      (snap),
      .snap_col  (snap_col),
      .snap_row  (snap_row),
      .snap_ox   (snap_ox),
      .snap_oy   (snap_oy)
   );

   mcr_emit #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .snap        (snap),
      .snap_col    (snap_col),
      .snap_row    (snap_row),
      .snap_ox     (snap_ox),
      .snap_oy     (snap_oy),
      .step_ready  (req_tready),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_kind    (out_kind),
      .out_x_left  (out_xl),
      .out_x_right (out_xr),
      .out_row_y   (out_ry),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {{OUT_PAD_W{1'b0}}, out_ry, out_xr, out_xl};
   assign rsp_tuser = out_kind;

   // A done marker is always the only and final result of its tick.
   a_done_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kind == KIND_DONE) |-> rsp_tlast)
      else $error("done marker without last");

   a_done_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kind == KIND_DONE) |-> (out_xl == '0 && out_xr == '0 && out_ry == '0))
      else $error("done marker with nonzero coordinates");

   // A point has equal left and right columns.
   a_point_width : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kind == KIND_POINT) |-> (out_xl == out_xr))
      else $error("point with differing columns");

   a_ready_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready)
      else $error("input not ready after reset");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   import mcr_pkg::*;

   localparam int COORD_W = COORD_BITS_DEF;
   localparam int RAD_W   = RADIUS_BITS_DEF;
   localparam int REQ_W   = ((2 * COORD_W + RAD_W + 1 + 7) / 8) * 8;
   localparam int TAIL_ITEMS = 30;

   typedef struct {
      cmd_type          cmd;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [RAD_W-1:0]   rad;
      logic             fill;
      bit               hold;
   } stim_type;

   typedef struct packed {
      kind_type         kind;
      logic [OUT_W-1:0] x_left;
      logic [OUT_W-1:0] x_right;
      logic [OUT_W-1:0] row_y;
      logic             is_last;
   } prim_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic [0:0]        req_tuser = CMD_START;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic              rsp_tlast;

   stim_type cmd_q[$];
   prim_type prim_q[$];
   int    mismatch_cnt = 0;
   int    req_total = 0;
   int    taken_cnt = 0;
   logic  drained = 1'b1;
   logic  tail_mode = 1'b0;
   int    send_gap = 0;
   int    stall_left = 0;

   // Shadow copy of the circle walk.
   logic [COORD_W-1:0] ctr_col = '0;
   logic [COORD_W-1:0] ctr_row = '0;
   int        walk_rad = 0;
   logic      fill_held = 1'b0;
   int        off_x = 0;
   int        off_y = 0;
   int        dec = 0;
   phase_type walk_phase = PH_DONE;

   midpoint_circle_rasterizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_cnt++;
   endtask

   task automatic queue_cmd(input cmd_type c, input int cx, input int cy, input int r,
                            input int fl, input bit hold);
      stim_type s;
      s.cmd  = c;
      s.cx   = cx[COORD_W-1:0];
      s.cy   = cy[COORD_W-1:0];
      s.rad  = r[RAD_W-1:0];
      s.fill = fl[0];
      s.hold = hold;
      cmd_q = {cmd_q, s};
   endtask

   task automatic push_prim(input kind_type k, input int xl, input int xr, input int ry,
                            input logic lst);
      prim_type p;
      p.kind    = k;
      p.x_left  = xl[OUT_W-1:0];
      p.x_right = xr[OUT_W-1:0];
      p.row_y   = ry[OUT_W-1:0];
      p.is_last = lst;
      prim_q = {prim_q, p};
   endtask

   function automatic void restart_walk();
      off_x = 0;
      off_y = walk_rad;
      dec   = walk_rad - 1;
   endfunction

   // One decision step of the walk; true once the octant is covered.
   function automatic bit step_walk();
      if (dec >= 2 * off_x) begin
         dec -= 2 * off_x + 1;
         off_x++;
      end else if (dec < 2 * (walk_rad - off_y)) begin
         dec += 2 * off_y - 1;
         off_y--;
      end else begin
         dec += 2 * (off_y - off_x - 1);
         off_y--;
         off_x++;
      end
      return off_y < off_x;
   endfunction

   task automatic rasterize_item(input logic [0:0] cmd, input logic [REQ_W-1:0] d);
      int x, y, a, b;
      if (cmd == CMD_START) begin
         ctr_col    = d[COORD_W-1:0];
         ctr_row    = d[2*COORD_W-1:COORD_W];
         walk_rad   = d[2*COORD_W+RAD_W-1:2*COORD_W];
         fill_held  = d[2*COORD_W+RAD_W];
         restart_walk();
         walk_phase = PH_OUTLINE;
      end else begin
         x = ctr_col;
         y = ctr_row;
         a = off_x;
         b = off_y;
         case (walk_phase)
            PH_OUTLINE: begin
               push_prim(KIND_POINT, x + a, x + a, y + b, 1'b0);
               push_prim(KIND_POINT, x + b, x + b, y + a, 1'b0);
               push_prim(KIND_POINT, x - a, x - a, y + b, 1'b0);
               push_prim(KIND_POINT, x - b, x - b, y + a, 1'b0);
               push_prim(KIND_POINT, x + a, x + a, y - b, 1'b0);
               push_prim(KIND_POINT, x + b, x + b, y - a, 1'b0);
               push_prim(KIND_POINT, x - a, x - a, y - b, 1'b0);
               push_prim(KIND_POINT, x - b, x - b, y - a, 1'b1);
               if (step_walk()) begin
                  if (fill_held) begin
                     restart_walk();
                     walk_phase = PH_FILL;
                  end else begin
                     walk_phase = PH_DONE;
                  end
               end
            end
            PH_FILL: begin
               push_prim(KIND_SPAN, x - b, x + b, y + a, 1'b0);
               push_prim(KIND_SPAN, x - a, x + a, y + b, 1'b0);
               push_prim(KIND_SPAN, x - a, x + a, y - b, 1'b0);
               push_prim(KIND_SPAN, x - b, x + b, y - a, 1'b1);
               if (step_walk()) walk_phase = PH_DONE;
            end
            default: begin
               push_prim(KIND_DONE, 0, 0, 0, 1'b1);
            end
         endcase
      end
   endtask

   task automatic check_prim();
      prim_type w;
      if (prim_q.size() == 0) begin
         flag_mismatch($sformatf("result kind %0d arrived with nothing pending", rsp_tuser));
         return;
      end
      w = prim_q.pop_front();
      if (rsp_tuser !== w.kind)
         flag_mismatch($sformatf("kind got %0d want %0d", rsp_tuser, w.kind));
      if (rsp_tdata[OUT_W-1:0] !== w.x_left)
         flag_mismatch($sformatf("x_left got %0d want %0d",
                                 $signed(rsp_tdata[OUT_W-1:0]), $signed(w.x_left)));
      if (rsp_tdata[2*OUT_W-1:OUT_W] !== w.x_right)
         flag_mismatch($sformatf("x_right got %0d want %0d",
                                 $signed(rsp_tdata[2*OUT_W-1:OUT_W]), $signed(w.x_right)));
      if (rsp_tdata[3*OUT_W-1:2*OUT_W] !== w.row_y)
         flag_mismatch($sformatf("row_y got %0d want %0d",
                                 $signed(rsp_tdata[3*OUT_W-1:2*OUT_W]), $signed(w.row_y)));
      if (rsp_tlast !== w.is_last)
         flag_mismatch($sformatf("last got %0b want %0b", rsp_tlast, w.is_last));
   endtask

   // Driver: presents queued commands, with random gaps between transactions before the tail.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready && !tail_mode && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 10);
         if (req_tvalid && !req_tready) begin
            // Stalled transaction stays on the bus unchanged.
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (cmd_q.size() > 0 && !(cmd_q[0].hold && (req_tvalid || !drained))) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_W'({cmd_q[0].fill, cmd_q[0].rad, cmd_q[0].cy, cmd_q[0].cx});
            req_tuser  <= cmd_q[0].cmd;
            void'(cmd_q.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
         tail_mode <= (cmd_q.size() <= TAIL_ITEMS);
      end
   end

   // Monitor: checks results first, then predicts from the command taken at this edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         drained    <= 1'b1;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_prim();
         if (req_tvalid && req_tready) begin
            rasterize_item(req_tuser, req_tdata);
            taken_cnt <= taken_cnt + 1;
         end
         drained <= (prim_q.size() == 0);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!tail_mode && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int r, fl, cx, cy, n, seq_no;
      bit big;

      // Directed: tick straight after reset, zero radius with fill, corner circles.
      queue_cmd(CMD_TICK, 0, 0, 0, 0, 1'b0);
      queue_cmd(CMD_START, 0, 0, 0, 1, 1'b0);
      repeat (3) queue_cmd(CMD_TICK, 0, 0, 0, 0, 1'b0);
      queue_cmd(CMD_START, 4095, 4095, 1023, 1, 1'b0);
      repeat (3) queue_cmd(CMD_TICK, 4095, 4095, 1023, 1, 1'b0);
      queue_cmd(CMD_START, 0, 4095, 1023, 0, 1'b0);
      repeat (2) queue_cmd(CMD_TICK, 0, 0, 0, 0, 1'b0);
      queue_cmd(CMD_START, 4095, 0, 1, 0, 1'b0);
      repeat (3) queue_cmd(CMD_TICK, 0, 0, 0, 0, 1'b0);
      queue_cmd(CMD_START, 100, 200, 3, 1, 1'b1);
      repeat (8) queue_cmd(CMD_TICK, 0, 0, 0, 0, 1'b0);

      // Random circles: mostly complete walks, some cut short by a new start.
      seq_no = 0;
      while (cmd_q.size() < 190) begin
         big = ($urandom_range(0, 7) == 0);
         r   = big ? $urandom_range(0, 1023) : $urandom_range(0, 24);
         fl  = $urandom_range(0, 1);
         if ($urandom_range(0, 3) == 0) begin
            cx = $urandom_range(0, 1) * 4095;
            cy = $urandom_range(0, 1) * 4095;
         end else begin
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
         end
         // Enough ticks to cover each phase, plus a few that hit the done state.
         n = (r * 3) / 4 + 2;
         if (fl) n = 2 * n;
         n += $urandom_range(0, 2);
         if (big || $urandom_range(0, 5) == 0) n = $urandom_range(0, big ? 6 : n);
         queue_cmd(CMD_START, cx, cy, r, fl, seq_no % 6 == 0);
         repeat (n) queue_cmd(CMD_TICK, $urandom, $urandom, $urandom, $urandom, 1'b0);
         seq_no++;
      end
      req_total = cmd_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (taken_cnt != req_total || !drained);
      repeat (24) @(posedge clock);
      if (prim_q.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", prim_q.size()));
      if (mismatch_cnt == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mcr_pkg.sv
rtl/core/mcr_walk.sv
rtl/core/mcr_emit.sv
rtl/core/midpoint_circle_rasterizer_unit.sv
bench/tb_top.sv
